// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared same-cycle and next-cycle implication assertion forms.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mrric_pkg.sv =====
// ---------------------------------------------------------------------------
// mrric_pkg
// Types and constants of the multi-reader ring index controller.
// ---------------------------------------------------------------------------
package mrric_pkg;

	localparam int POS_W     = 10;
	localparam int RDR_W     = 3;
	localparam int HOR_W     = 10;
	localparam int QS_W      = 11;
	localparam int RC_W      = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 11;

	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_READER_COUNT = 2'd1;

	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_NEXT   = 2'd1,
		KIND_LATEST = 2'd2,
		KIND_QUERY  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		STAT_OK            = 3'd0,
		STAT_BAD_READER    = 3'd1,
		STAT_NEVER_WRITTEN = 3'd2,
		STAT_EMPTY         = 3'd3,
		STAT_FULL          = 3'd4,
		STAT_HORIZON       = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_EXEC,
		ST_DONE
	} fsm_state_t;

	typedef struct packed {
		kind_t              kind;
		logic [RDR_W-1:0]   reader;
		logic [HOR_W-1:0]   horizon;
	} in_item_t;

	typedef struct packed {
		status_t            status;
		logic [POS_W-1:0]   position;
		logic [POS_W-1:0]   write_peek;
		logic [POS_W-1:0]   unread_count;
	} out_item_t;

endpackage

// ===== rtl/multi_reader_ring_index_control.sv =====
// ---------------------------------------------------------------------------
// multi_reader_ring_index_control
// Write and read slot indices of a ring with one writer and several readers.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------
//  in       | input     | in_valid / in_ready        | in_item  (in_item_t)
//  out      | output    | out_valid / out_ready      | out_item (out_item_t)
//  cfg      | input     | cfg_we (no wait)           | cfg_index, cfg_data
//
//  Read and query items pass reader fetch, update and hand-off. Items refused
//  for a bad reader or an unwritten ring, and the first write after reset, pass
//  accept and hand-off. Any other write item scans every configured reader
//  before hand-off: the full check reads the reader position memory one entry
//  per cycle through its single read port. One item is in work at a time; the
//  output register lets the next item in while a result waits. Reset returns
//  all state to its initial values; a queue size or reader count write restarts
//  the ring. Reader entries carry a per-entry valid bit, no sweep.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_reader_ring_index_control
	import mrric_pkg::*;
#(
	parameter int DEPTH       = 1024,
	parameter int MAX_READERS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int SW = $clog2(DEPTH + 1);
	localparam int RW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
	localparam int CW = $clog2(MAX_READERS + 1);
	localparam int AW = ((SW > HOR_W) ? SW : HOR_W) + 1;

	fsm_state_t state_q, state_d;

	logic [SW-1:0]          size_q;
	logic [CW-1:0]          nrd_q;
	logic [PW-1:0]          ws_q;
	logic                   nw_q;
	logic [MAX_READERS-1:0] pend_q;
	logic [RW-1:0]          scan_q;
	logic                   full_q;
	logic                   cmp_vld_s1;
	logic                   out_valid_q;
	in_item_t               item_q;
	out_item_t              res_q, res_d;
	out_item_t              out_item_q;

	logic [PW-1:0] mem [MAX_READERS];
	logic [PW-1:0] rd_data_s1;
	logic          rd_live_s1;

	logic          accept, out_load, rd_en, wr_en, res_ld, nw_clr, ws_adv;
	logic [RW-1:0] rd_addr, wr_addr;
	logic [PW-1:0] wr_data, rd_val;
	logic          bad_rdr, scan_last, scan_hit;
	logic [SW-1:0] size_cfg;
	logic [CW-1:0] nrd_cfg;

	logic [AW-1:0] ws_a, size_a, r_a, h_a;
	logic [AW-1:0] ws_inc, ws_next, ahead, ahead2, r_inc, r_next;
	logic [AW-1:0] q_pos, q_peek, q_unread;

	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	assign bad_rdr   = 32'(in_item.reader) >= 32'(nrd_q);
	assign scan_last = (32'(scan_q) + 32'd1) == 32'(nrd_q);
	assign rd_val    = rd_live_s1 ? rd_data_s1 : '0;
	assign wr_addr   = RW'(item_q.reader);

	assign size_cfg = (cfg_data < CFG_W'(2)) ? SW'(2) :
		(32'(cfg_data) > 32'(DEPTH)) ? SW'(DEPTH) : SW'(cfg_data);
	assign nrd_cfg  = (cfg_data[RC_W-1:0] == '0) ? CW'(1) :
		(32'(cfg_data[RC_W-1:0]) > 32'(MAX_READERS)) ? CW'(MAX_READERS) :
		CW'(cfg_data[RC_W-1:0]);

	assign ws_a     = AW'(ws_q);
	assign size_a   = AW'(size_q);
	assign r_a      = AW'(rd_val);
	assign h_a      = AW'(item_q.horizon);
	assign ws_inc   = ws_a + AW'(1);
	assign ws_next  = (ws_inc == size_a) ? '0 : ws_inc;
	assign ahead    = ws_a + AW'(2);
	assign ahead2   = (ahead >= size_a) ? ahead - size_a : ahead;
	assign r_inc    = r_a + AW'(1);
	assign r_next   = (r_inc == size_a) ? '0 : r_inc;
	assign q_pos    = (r_a >= h_a) ? r_a - h_a : r_a + size_a - h_a;
	assign q_peek   = (ws_a >= h_a) ? ws_a - h_a : ws_a + size_a - h_a;
	assign q_unread = (ws_a >= r_a) ? ws_a - r_a : ws_a + size_a - r_a;
	assign scan_hit = cmp_vld_s1 && (r_a == ahead2);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_item.kind == KIND_WRITE) begin
						state_d = nw_q ? ST_DONE : ST_SCAN;
					end else if (bad_rdr || nw_q) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_EXEC;
					end
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_SCAN_LAST;
				end
			end
			ST_SCAN_LAST: state_d = ST_DONE;
			ST_EXEC:      state_d = ST_DONE;
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = scan_q;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				rd_en    = in_valid;
				rd_addr  = RW'(in_item.reader);
			end
			ST_SCAN: begin
				rd_en = 1'b1;
			end
			ST_DONE: begin
				out_load = !out_valid_q || out_ready;
			end
			default: ;
		endcase
	end

	always_comb begin
		res_d   = '{status: STAT_OK, default: '0};
		res_ld  = 1'b0;
		nw_clr  = 1'b0;
		ws_adv  = 1'b0;
		wr_en   = 1'b0;
		wr_data = ws_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_ld = 1'b1;
					if (in_item.kind == KIND_WRITE) begin
						if (nw_q) begin
							res_d.position = POS_W'(ws_q);
							nw_clr         = 1'b1;
						end else begin
							res_ld = 1'b0;
						end
					end else if (bad_rdr) begin
						res_d.status = STAT_BAD_READER;
					end else if (nw_q) begin
						res_d.status = STAT_NEVER_WRITTEN;
					end else begin
						res_ld = 1'b0;
					end
				end
			end
			ST_SCAN_LAST: begin
				res_ld         = 1'b1;
				ws_adv         = 1'b1;
				res_d.status   = (full_q || scan_hit) ? STAT_FULL : STAT_OK;
				res_d.position = POS_W'(ws_next);
			end
			ST_EXEC: begin
				res_ld = 1'b1;
				if (item_q.kind == KIND_QUERY) begin
					if (h_a > size_a) begin
						res_d.status = STAT_HORIZON;
					end else begin
						res_d.position     = POS_W'(q_pos);
						res_d.write_peek   = POS_W'(q_peek);
						res_d.unread_count = POS_W'(q_unread);
					end
				end else if (!rd_live_s1) begin
					wr_en          = 1'b1;
					wr_data        = (item_q.kind == KIND_LATEST) ? ws_q : rd_val;
					res_d.position = POS_W'(wr_data);
				end else if (rd_val == ws_q) begin
					res_d.status = STAT_EMPTY;
				end else begin
					wr_en          = 1'b1;
					wr_data        = (item_q.kind == KIND_NEXT) ? PW'(r_next) : ws_q;
					res_d.position = POS_W'(wr_data);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			size_q      <= SW'(DEPTH);
			nrd_q       <= CW'(1);
			ws_q        <= '0;
			nw_q        <= 1'b1;
			pend_q      <= '1;
			scan_q      <= '0;
			full_q      <= 1'b0;
			cmp_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= (state_q == ST_SCAN);
			if (cfg_we) begin
				case (cfg_index)
					REG_QUEUE_SIZE: begin
						size_q <= size_cfg;
						ws_q   <= '0;
						nw_q   <= 1'b1;
						pend_q <= '1;
					end
					REG_READER_COUNT: begin
						nrd_q  <= nrd_cfg;
						ws_q   <= '0;
						nw_q   <= 1'b1;
						pend_q <= '1;
					end
					default: ;
				endcase
			end else begin
				if (nw_clr) begin
					nw_q <= 1'b0;
				end
				if (ws_adv) begin
					ws_q <= PW'(ws_next);
				end
				if (wr_en) begin
					pend_q[wr_addr] <= 1'b0;
				end
			end
			if (state_q == ST_IDLE) begin
				scan_q <= '0;
				full_q <= 1'b0;
			end else begin
				if (state_q == ST_SCAN) begin
					scan_q <= scan_q + RW'(1);
				end
				if (scan_hit) begin
					full_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_item;
		end
		if (res_ld) begin
			res_q <= res_d;
		end
		if (out_load) begin
			out_item_q <= res_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_live_s1 <= !pend_q[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	`ASSERT_NOW(a_wr_in_exec, wr_en, state_q == ST_EXEC, "reader memory written outside update")
	`ASSERT_NOW(a_ws_in_ring, 1'b1, ws_a < size_a, "write position outside ring")
	`ASSERT_NOW(a_scan_range, state_q == ST_SCAN, 32'(scan_q) < 32'(nrd_q), "scan past readers")
	`ASSERT_NEXT(a_handoff, out_load, out_valid && state_q == ST_IDLE, "result hand-off lost")

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-reader ring index controller. A fixed
// table of corner items runs first, then random phases under changing ring
// sizes and reader counts. Every result is compared field by field with the
// table's typed result or an in-bench model of the write and read positions.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mrric_pkg::*;

	localparam int RING_DEPTH  = 1024;
	localparam int HEAD_MAX    = 8;
	localparam int SETTLE      = HEAD_MAX + 4;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES      = 16;
	localparam int PHASE_ITEMS = 100;
	localparam int CORNERS     = 6;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

	localparam int CORNER_QS [CORNERS] = '{2, 1024, 2047, 0, 3, 1};
	localparam int CORNER_RC [CORNERS] = '{8, 8, 1, 15, 0, 4};

	typedef struct packed {
		bit                   cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     val;
		kind_t                kind;
		logic [RDR_W-1:0]     reader;
		logic [HOR_W-1:0]     horizon;
		bit                   typed;
		status_t              status;
		logic [POS_W-1:0]     position;
		logic [POS_W-1:0]     write_peek;
		logic [POS_W-1:0]     unread_count;
	} plan_row_t;

	plan_row_t plan [30] = '{
		'{0, REG_QUEUE_SIZE,   0,    KIND_QUERY,  0, 0,    1, STAT_NEVER_WRITTEN, 0, 0, 0},
		'{0, REG_QUEUE_SIZE,   0,    KIND_NEXT,   0, 0,    1, STAT_NEVER_WRITTEN, 0, 0, 0},
		'{0, REG_QUEUE_SIZE,   0,    KIND_LATEST, 7, 0,    1, STAT_BAD_READER,    0, 0, 0},
		'{0, REG_QUEUE_SIZE,   0,    KIND_WRITE,  0, 0,    1, STAT_OK,            0, 0, 0},
		'{0, REG_QUEUE_SIZE,   0,    KIND_QUERY,  0, 0,    1, STAT_OK,            0, 0, 0},
		'{0, REG_QUEUE_SIZE,   0,    KIND_NEXT,   0, 0,    1, STAT_OK,            0, 0, 0},
		'{0, REG_QUEUE_SIZE,   0,    KIND_NEXT,   0, 0,    1, STAT_EMPTY,         0, 0, 0},
		'{0, REG_QUEUE_SIZE,   0,    KIND_WRITE,  7, 1023, 1, STAT_OK,            1, 0, 0},
		'{0, REG_QUEUE_SIZE,   0,    KIND_LATEST, 0, 0,    0, STAT_OK,            0, 0, 0},
		'{0, REG_QUEUE_SIZE,   0,    KIND_QUERY,  0, 1023, 0, STAT_OK,            0, 0, 0},
		'{0, REG_QUEUE_SIZE,   0,    KIND_QUERY,  1, 0,    1, STAT_BAD_READER,    0, 0, 0},
		'{1, REG_READER_COUNT, 15,   KIND_WRITE,  0, 0,    0, STAT_OK,            0, 0, 0},
		'{0, REG_QUEUE_SIZE,   0,    KIND_WRITE,  0, 0,    1, STAT_OK,            0, 0, 0},
		'{0, REG_QUEUE_SIZE,   0,    KIND_LATEST, 7, 0,    1, STAT_OK,            0, 0, 0},
		'{0, REG_QUEUE_SIZE,   0,    KIND_QUERY,  7, 1023, 0, STAT_OK,            0, 0, 0},
		'{1, REG_QUEUE_SIZE,   2,    KIND_WRITE,  0, 0,    0, STAT_OK,            0, 0, 0},
		'{0, REG_QUEUE_SIZE,   0,    KIND_WRITE,  0, 0,    1, STAT_OK,            0, 0, 0},
		'{0, REG_QUEUE_SIZE,   0,    KIND_WRITE,  0, 0,    1, STAT_FULL,          1, 0, 0},
		'{0, REG_QUEUE_SIZE,   0,    KIND_QUERY,  3, 3,    1, STAT_HORIZON,       0, 0, 0},
		'{0, REG_QUEUE_SIZE,   0,    KIND_QUERY,  3, 2,    0, STAT_OK,            0, 0, 0},
		'{0, REG_QUEUE_SIZE,   0,    KIND_NEXT,   3, 0,    0, STAT_OK,            0, 0, 0},
		'{0, REG_QUEUE_SIZE,   0,    KIND_NEXT,   3, 0,    0, STAT_OK,            0, 0, 0},
		'{1, REG_SPARE,        2047, KIND_WRITE,  0, 0,    0, STAT_OK,            0, 0, 0},
		'{0, REG_QUEUE_SIZE,   0,    KIND_NEXT,   3, 0,    0, STAT_OK,            0, 0, 0},
		'{1, REG_QUEUE_SIZE,   0,    KIND_WRITE,  0, 0,    0, STAT_OK,            0, 0, 0},
		'{1, REG_READER_COUNT, 0,    KIND_WRITE,  0, 0,    0, STAT_OK,            0, 0, 0},
		'{0, REG_QUEUE_SIZE,   0,    KIND_WRITE,  0, 0,    0, STAT_OK,            0, 0, 0},
		'{0, REG_QUEUE_SIZE,   0,    KIND_WRITE,  0, 0,    0, STAT_OK,            0, 0, 0},
		'{1, REG_QUEUE_SIZE,   2047, KIND_WRITE,  0, 0,    0, STAT_OK,            0, 0, 0},
		'{0, REG_QUEUE_SIZE,   0,    KIND_QUERY,  0, 1023, 1, STAT_NEVER_WRITTEN, 0, 0, 0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_item_t             in_item = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_item;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// model of the ring positions
	logic [QS_W-1:0] qsize_reg = QS_W'(RING_DEPTH);
	logic [RC_W-1:0] rcount_reg = RC_W'(1);
	int unsigned     wr_slot;
	bit              unwritten;
	int unsigned     rd_slot [HEAD_MAX];
	bit              first_pending [HEAD_MAX];

	out_item_t due_q [$];
	int        errors = 0;
	int        quiet = 0;
	bit        tx_idle = 1'b1;

	multi_reader_ring_index_control #(
		.DEPTH       (RING_DEPTH),
		.MAX_READERS (HEAD_MAX)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned ring_len();
		if (qsize_reg < 2) return 2;
		if (qsize_reg > RING_DEPTH) return RING_DEPTH;
		return 32'(qsize_reg);
	endfunction

	function automatic int unsigned head_count();
		if (rcount_reg < 1) return 1;
		if (rcount_reg > HEAD_MAX) return HEAD_MAX;
		return 32'(rcount_reg);
	endfunction

	function automatic void clear_ring();
		wr_slot = 0;
		unwritten = 1'b1;
		for (int n = 0; n < HEAD_MAX; n++) begin
			rd_slot[n] = 0;
			first_pending[n] = 1'b1;
		end
	endfunction

	function automatic int unsigned back_off(int unsigned pos, int unsigned hor,
			int unsigned sz);
		return (pos >= hor) ? pos - hor : pos + sz - hor;
	endfunction

	function automatic out_item_t step_ring(in_item_t it);
		out_item_t   r;
		int unsigned sz;
		int unsigned nh;
		int unsigned ahead;
		int unsigned cur;
		int unsigned rd;
		sz = ring_len();
		nh = head_count();
		rd = 32'(it.reader);
		r = '0;
		r.status = STAT_OK;
		if (it.kind == KIND_WRITE) begin
			if (unwritten) begin
				unwritten = 1'b0;
			end else begin
				ahead = (wr_slot + 2) % sz;
				for (int n = 0; n < nh; n++) begin
					if (rd_slot[n] == ahead) r.status = STAT_FULL;
				end
				wr_slot = (wr_slot + 1) % sz;
			end
			r.position = POS_W'(wr_slot);
		end else if (rd >= nh) begin
			r.status = STAT_BAD_READER;
		end else if (unwritten) begin
			r.status = STAT_NEVER_WRITTEN;
		end else if (it.kind == KIND_QUERY) begin
			if (it.horizon > sz) begin
				r.status = STAT_HORIZON;
			end else begin
				cur = rd_slot[rd];
				r.position = POS_W'(back_off(cur, 32'(it.horizon), sz));
				r.write_peek = POS_W'(back_off(wr_slot, 32'(it.horizon), sz));
				r.unread_count = POS_W'((wr_slot >= cur) ? wr_slot - cur :
					sz - (cur - wr_slot));
			end
		end else if (first_pending[rd]) begin
			if (it.kind == KIND_LATEST) rd_slot[rd] = wr_slot;
			first_pending[rd] = 1'b0;
			r.position = POS_W'(rd_slot[rd]);
		end else if (rd_slot[rd] == wr_slot) begin
			r.status = STAT_EMPTY;
		end else begin
			if (it.kind == KIND_NEXT) rd_slot[rd] = (rd_slot[rd] + 1) % sz;
			else rd_slot[rd] = wr_slot;
			r.position = POS_W'(rd_slot[rd]);
		end
		return r;
	endfunction

	task automatic offer_item(in_item_t it, bit typed, out_item_t typed_res);
		int unsigned gap;
		out_item_t   pred;
		gap = tx_idle ? $urandom_range(0, 10) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_ready !== 1'b1);
		pred = step_ring(it);
		due_q.push_back(typed ? typed_res : pred);
	endtask

	// hold off until every result is back and the block has gone quiet
	task automatic drain_ring();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_QUEUE_SIZE) begin
			qsize_reg = val;
			clear_ring();
		end else if (idx == REG_READER_COUNT) begin
			rcount_reg = val[RC_W-1:0];
			clear_ring();
		end
	endtask

	task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	initial begin
		in_item_t    it;
		out_item_t   typed_res;
		int unsigned sz;
		int unsigned nh;
		int unsigned lim;
		int unsigned wr_pct;
		int unsigned qs;
		int unsigned rc;
		clear_ring();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].cfg) begin
				drain_ring();
				write_reg(plan[i].idx, plan[i].val);
			end else begin
				it.kind = plan[i].kind;
				it.reader = plan[i].reader;
				it.horizon = plan[i].horizon;
				typed_res.status = plan[i].status;
				typed_res.position = plan[i].position;
				typed_res.write_peek = plan[i].write_peek;
				typed_res.unread_count = plan[i].unread_count;
				offer_item(it, plan[i].typed, typed_res);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			drain_ring();
			if (p < CORNERS) begin
				qs = CORNER_QS[p];
				rc = CORNER_RC[p];
			end else begin
				qs = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) : $urandom_range(2, 12);
				rc = $urandom_range(0, 15);
			end
			write_reg(REG_QUEUE_SIZE, CFG_W'(qs));
			write_reg(REG_READER_COUNT, CFG_W'(rc));
			tx_idle = ($urandom_range(0, 3) != 0);
			wr_pct = $urandom_range(20, 60);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 39) == 0) drain_ring();
				sz = ring_len();
				nh = head_count();
				if ($urandom_range(0, 99) < wr_pct) begin
					it.kind = KIND_WRITE;
				end else begin
					case ($urandom_range(0, 3))
						0, 1: it.kind = KIND_NEXT;
						2: it.kind = KIND_LATEST;
						default: it.kind = KIND_QUERY;
					endcase
				end
				if ($urandom_range(0, 9) == 0) it.reader = RDR_W'($urandom_range(0, 7));
				else it.reader = RDR_W'($urandom_range(0, nh - 1));
				lim = (sz < 1023) ? sz + 1 : 1023;
				if ($urandom_range(0, 3) == 0) it.horizon = HOR_W'($urandom_range(0, 1023));
				else it.horizon = HOR_W'($urandom_range(0, lim));
				offer_item(it, 1'b0, '0);
			end
		end

		drain_ring();
		repeat (30) @(posedge clk);
		if (errors == 0) begin
			$display("multi_reader_ring_index_control: match");
		end else begin
			$display("multi_reader_ring_index_control: mismatch");
		end
		$finish;
	end

	initial begin
		int unsigned stall;
		bit          rx_idle;
		out_item_t   want;
		rx_idle = 1'b1;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0) rx_idle = !rx_idle;
			stall = rx_idle ? $urandom_range(0, 10) : 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (due_q.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, expected none got %p",
					$time, out_item);
			end else begin
				want = due_q.pop_front();
				cmp_field("status", 32'(want.status), 32'(out_item.status));
				cmp_field("position", 32'(want.position), 32'(out_item.position));
				cmp_field("write_peek", 32'(want.write_peek), 32'(out_item.write_peek));
				cmp_field("unread_count", 32'(want.unread_count),
					32'(out_item.unread_count));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("multi_reader_ring_index_control: mismatch");
			$finish;
		end
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mrric_pkg.sv
rtl/multi_reader_ring_index_control.sv
tb/sv/tb_top.sv
